@@ src/mhl_pkg.sv @@
// Shared types and constants of the multiclass hinge loss block.
`default_nettype none

package mhl_pkg;

    // Command codes of an input word.
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_BACKWARD = 1'b1;

    // Kind codes of a result word; jobs in the queue use the same codes.
    localparam logic KIND_LOSS = 1'b0;
    localparam logic KIND_GRAD = 1'b1;

    // Status codes of a loss result.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_CLASS = 1'b1;

    // Register map: one register, selected by address bit 2.
    localparam int  ADDR_W     = 3;
    localparam logic REG_MARGIN = 1'b0;
    localparam logic [30:0] MARGIN_RESET = 31'd65536;

    localparam logic [30:0] LOSS_MAX = 31'h7FFF_FFFF;

    // Job queue between the front and back parts.
    localparam int JOB_CNT_W = 7;
    localparam int Q_DEPTH   = 2;

    typedef struct packed {
        logic               command;
        logic signed [31:0] score;
        logic [5:0]         target_class;
        logic signed [31:0] upstream_grad;
        logic               last;
    } in_t;

    typedef struct packed {
        logic               kind;
        logic [30:0]        loss;
        logic [5:0]         element_index;
        logic signed [31:0] gradient;
        logic               status;
        logic               final_res;
    } out_t;

    typedef struct packed {
        logic                 kind;
        logic [JOB_CNT_W-1:0] count;
        logic [5:0]           target;
        logic signed [31:0]   grad;
    } job_t;

endpackage

`default_nettype wire

@@ src/mhl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mhl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ src/mhl_front.sv @@
// Front part: accepts words, stores scores, tracks the vector and queues jobs.
`default_nettype none

module mhl_front #(
    parameter int MAX_CLASSES = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire mhl_pkg::in_t                   item,
    input  wire logic                           back_busy,
    input  wire logic                           job_pop,
    output logic                                busy,
    output logic                                job_valid,
    output mhl_pkg::job_t                       job,
    output logic                                wr_en,
    output logic [$clog2(MAX_CLASSES)-1:0]      wr_addr,
    output logic [31:0]                         wr_data
);

    import mhl_pkg::*;

    localparam int CW = $clog2(MAX_CLASSES + 1);
    localparam int IW = $clog2(MAX_CLASSES);
    localparam int QW = $clog2(Q_DEPTH + 1);
    localparam int PW = $clog2(Q_DEPTH);

    logic [CW-1:0] cnt_reg;
    logic          closed_reg;
    logic [5:0]    tgt_reg;

    logic [CW-1:0] cnt_base;
    logic [CW-1:0] cnt_new;
    logic          room;
    logic          accept;
    logic          push;
    logic          push_loss;
    logic          push_grad;
    job_t          push_job;

    job_t          q_mem [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [QW-1:0] q_cnt_reg;

    assign busy   = back_busy || (q_cnt_reg != '0);
    assign accept = start && !busy;

    // A load after a closed vector starts a new one from slot zero.
    assign cnt_base = closed_reg ? '0 : cnt_reg;
    assign room     = cnt_base < CW'(MAX_CLASSES);
    assign cnt_new  = room ? cnt_base + CW'(1) : cnt_base;

    assign wr_en   = accept && (item.command == CMD_LOAD) && room;
    assign wr_addr = cnt_base[IW-1:0];
    assign wr_data = item.score;

    assign push_loss = accept && (item.command == CMD_LOAD) && item.last;
    assign push_grad = accept && (item.command == CMD_BACKWARD) && closed_reg
                       && (cnt_reg != '0);
    assign push      = push_loss || push_grad;

    always_comb
    begin
        push_job        = '0;
        push_job.grad   = item.upstream_grad;
        if (push_loss)
        begin
            push_job.kind   = KIND_LOSS;
            push_job.count  = JOB_CNT_W'(cnt_new);
            push_job.target = item.target_class;
        end
        else
        begin
            push_job.kind   = KIND_GRAD;
            push_job.count  = JOB_CNT_W'(cnt_reg);
            push_job.target = tgt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            closed_reg <= 1'b0;
            tgt_reg    <= '0;
        end
        else if (accept && (item.command == CMD_LOAD))
        begin
            cnt_reg    <= cnt_new;
            closed_reg <= item.last;
            if (item.last)
            begin
                tgt_reg <= item.target_class;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (job_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !job_pop)
            begin
                q_cnt_reg <= q_cnt_reg + QW'(1);
            end
            else if (job_pop && !push)
            begin
                q_cnt_reg <= q_cnt_reg - QW'(1);
            end
        end
    end

    assign job_valid = (q_cnt_reg != '0);
    assign job       = q_mem[rd_ptr_reg];

endmodule

`default_nettype wire

@@ src/mhl_back.sv @@
// Back part: runs the loss pass and the gradient pass over the stored vector.
`default_nettype none

module mhl_back #(
    parameter int MAX_CLASSES = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [30:0]                    margin,
    input  wire logic                           job_valid,
    input  wire mhl_pkg::job_t                  job,
    output logic                                job_pop,
    output logic                                back_busy,
    output logic [$clog2(MAX_CLASSES)-1:0]      rd_addr,
    input  wire logic [31:0]                    rd_data,
    output logic                                strobe,
    output mhl_pkg::out_t                       result
);

    import mhl_pkg::*;

    localparam int CW = $clog2(MAX_CLASSES + 1);
    localparam int IW = $clog2(MAX_CLASSES);
    localparam int MW = CW + 33;
    localparam int NW = MW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TGT,
        S_RD,
        S_TM,
        S_FIN,
        S_MUL,
        S_NEG,
        S_GRAD
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          cnt_reg;
    logic [5:0]             tgt_reg;
    logic [CW-1:0]          j_reg;
    logic [CW-1:0]          viol_reg;
    logic                   nz_reg;
    logic [MAX_CLASSES-1:0] mask_reg;
    logic [30:0]            sum_reg;
    logic [32:0]            term_reg;
    logic signed [31:0]     st_reg;
    logic signed [31:0]     g_reg;
    logic signed [MW-1:0]   prod_reg;
    logic signed [31:0]     negsat_reg;
    logic                   strobe_reg;
    out_t                   result_reg;

    logic signed [33:0]     term_full;
    logic                   term_pos;
    logic                   at_target;
    logic                   at_end;
    logic [33:0]            sum_ext;
    logic [30:0]            sum_sat;
    logic signed [NW-1:0]   neg_full;
    logic signed [31:0]     neg_sat;
    logic signed [31:0]     inc;
    logic                   bad_class;

    assign back_busy = (state_reg != S_IDLE);
    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign rd_addr   = (state_reg == S_IDLE) ? job.target[IW-1:0] : j_reg[IW-1:0];
    assign bad_class = ({1'b0, job.target} >= job.count);

    assign at_target = (7'(j_reg) == {1'b0, tgt_reg});
    assign at_end    = ((j_reg + CW'(1)) == cnt_reg);

    // Hinge term of the element just read; exact in 34 bits.
    assign term_full = $signed({{2{rd_data[31]}}, rd_data})
                     - $signed({{2{st_reg[31]}}, st_reg})
                     + $signed({3'b000, margin});
    assign term_pos  = !term_full[33] && (term_full != '0) && !at_target;

    // Terms are never negative, so clamping after each add matches a
    // clamp of the running sum.
    assign sum_ext = {3'b000, sum_reg} + {1'b0, term_reg};
    assign sum_sat = (sum_ext[33:31] != '0) ? LOSS_MAX : sum_ext[30:0];

    assign neg_full = -$signed({prod_reg[MW-1], prod_reg});
    always_comb
    begin
        if (!neg_full[NW-1] && (neg_full[NW-2:31] != '0))
        begin
            neg_sat = 32'sh7FFF_FFFF;
        end
        else if (neg_full[NW-1] && (neg_full[NW-2:31] != '1))
        begin
            neg_sat = 32'sh8000_0000;
        end
        else
        begin
            neg_sat = neg_full[31:0];
        end
    end

    always_comb
    begin
        inc = '0;
        if (nz_reg)
        begin
            if (at_target)
            begin
                inc = negsat_reg;
            end
            else if (mask_reg[j_reg[IW-1:0]])
            begin
                inc = g_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            tgt_reg    <= '0;
            j_reg      <= '0;
            viol_reg   <= '0;
            nz_reg     <= 1'b0;
            mask_reg   <= '0;
            sum_reg    <= '0;
            term_reg   <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    strobe_reg <= job_valid && (job.kind == KIND_LOSS) && bad_class;
                    if (job_valid)
                    begin
                        cnt_reg <= CW'(job.count);
                        tgt_reg <= job.target;
                        j_reg   <= '0;
                        if (job.kind == KIND_LOSS)
                        begin
                            mask_reg <= '0;
                            sum_reg  <= '0;
                            term_reg <= '0;
                            viol_reg <= '0;
                            if (bad_class)
                            begin
                                nz_reg     <= 1'b0;
                                result_reg <= '{kind: KIND_LOSS, loss: '0,
                                               element_index: '0, gradient: '0,
                                               status: STATUS_BAD_CLASS,
                                               final_res: 1'b1};
                            end
                            else
                            begin
                                state_reg <= S_TGT;
                            end
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_TGT:
                begin
                    strobe_reg <= 1'b0;
                    state_reg  <= S_RD;
                end
                S_RD:
                begin
                    strobe_reg <= 1'b0;
                    sum_reg    <= sum_sat;
                    state_reg  <= S_TM;
                end
                S_TM:
                begin
                    strobe_reg              <= 1'b0;
                    term_reg                <= term_pos ? term_full[32:0] : '0;
                    mask_reg[j_reg[IW-1:0]] <= term_pos;
                    if (term_pos)
                    begin
                        viol_reg <= viol_reg + CW'(1);
                    end
                    j_reg     <= j_reg + CW'(1);
                    state_reg <= at_end ? S_FIN : S_RD;
                end
                S_FIN:
                begin
                    nz_reg     <= (sum_sat != '0);
                    strobe_reg <= 1'b1;
                    result_reg <= '{kind: KIND_LOSS, loss: sum_sat,
                                   element_index: '0, gradient: '0,
                                   status: STATUS_OK, final_res: 1'b1};
                    state_reg  <= S_IDLE;
                end
                S_MUL:
                begin
                    strobe_reg <= 1'b0;
                    state_reg  <= S_NEG;
                end
                S_NEG:
                begin
                    strobe_reg <= 1'b0;
                    state_reg  <= S_GRAD;
                end
                S_GRAD:
                begin
                    strobe_reg <= 1'b1;
                    result_reg <= '{kind: KIND_GRAD, loss: '0,
                                   element_index: 6'(j_reg), gradient: inc,
                                   status: STATUS_OK, final_res: at_end};
                    j_reg      <= j_reg + CW'(1);
                    if (at_end)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    strobe_reg <= 1'b0;
                    state_reg  <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_TGT)
        begin
            st_reg <= rd_data;
        end
        if ((state_reg == S_IDLE) && job_valid)
        begin
            g_reg <= job.grad;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= MW'($signed({1'b0, viol_reg})) * MW'(g_reg);
        end
        if (state_reg == S_NEG)
        begin
            negsat_reg <= neg_sat;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ src/multiclass_hinge_loss.sv @@
// Top level of the multiclass hinge loss block: register port, front, RAM, back.
//
// Input words are offered with start and taken at an edge where start is high
// and busy is low. A load word (command 0) stores one class score while the
// vector has room; a load not marked last gives no result and leaves busy
// low, so scores stream in at one word per cycle while busy is low. The load
// marked last closes the vector of N scores and queues the loss pass, which
// yields one loss word; each element takes a RAM read step and a hinge term
// step on the single read port of the score RAM. A target class at or beyond
// N gives a loss word with status 1 straight from the idle state. A backward
// word (command 1) after a closed vector queues the gradient pass, which forms
// and negates the product of violator count and upstream gradient, then emits
// N gradient words, one per cycle. Busy rises the cycle after the word that
// queues a pass and falls in the cycle that shows its last result.
// Each result word is shown for one cycle with strobe high; the receiver
// cannot stall, so nothing waits on it. Reset clears all control state and
// sets the margin register to 1.0; the score RAM needs no clearing because a
// slot is always loaded before it is read. The margin register lies at byte
// address 0; the user must write it only while the block is idle, as the
// block itself does not enforce this.
`default_nettype none

module multiclass_hinge_loss #(
    parameter int MAX_CLASSES = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire mhl_pkg::in_t                item,
    output logic                             strobe,
    output mhl_pkg::out_t                    result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mhl_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import mhl_pkg::*;

    localparam int IW = $clog2(MAX_CLASSES);

    logic [30:0]   margin_reg;
    logic          cfg_write;

    logic          back_busy;
    logic          job_pop;
    logic          job_valid;
    job_t          job;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [IW-1:0] rd_addr;
    logic [31:0]   rd_data;

    // Register port: always ready, address bit 2 selects the register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MARGIN);
    assign prdata    = (paddr[2] == REG_MARGIN) ? {1'b0, margin_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_write)
        begin
            margin_reg <= pwdata[30:0];
        end
    end

    // The front takes words and writes scores; the back reads them back once
    // the job that closes the vector reaches it through the queue.
    mhl_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .back_busy (back_busy),
        .job_pop   (job_pop),
        .busy      (busy),
        .job_valid (job_valid),
        .job       (job),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    mhl_ram #(
        .WIDTH (32),
        .DEPTH (MAX_CLASSES)
    ) u_score_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mhl_back #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .margin    (margin_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .back_busy (back_busy),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .strobe    (strobe),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ src/mhl_checker.sv @@
// Port-level checks of the multiclass hinge loss block and their binding.
`default_nettype none

module mhl_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          strobe,
    input  wire mhl_pkg::out_t result
);

    import mhl_pkg::*;

    // A loss word is always the only result of its input word.
    a_loss_final: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == KIND_LOSS) |-> result.final_res)
        else $error("loss word without final mark");

    // A bad target class reports a zero loss.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == KIND_LOSS) && (result.status == STATUS_BAD_CLASS)
        |-> (result.loss == '0))
        else $error("nonzero loss with bad class status");

    // Gradient words come back to back with rising element index.
    a_grad_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == KIND_GRAD) && !result.final_res
        |=> strobe && (result.kind == KIND_GRAD)
            && (result.element_index == 6'($past(result.element_index) + 6'd1)))
        else $error("gradient run broken");

    // Gradient words carry neither a loss nor an error.
    a_grad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == KIND_GRAD)
        |-> (result.loss == '0) && (result.status == STATUS_OK))
        else $error("gradient word with loss or status set");

endmodule

bind multiclass_hinge_loss mhl_checker u_mhl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench of the multiclass hinge loss block: predictor, driver and monitor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mhl_pkg::*;

    // The block holds at most this many class scores per vector.
    localparam int NUM_CLASSES = 64;
    // Pauses before a register write and at the end of the run are sized from
    // a loss pass on a full vector.
    localparam int SETTLE_CYCLES = 160;
    // Cycles in which no word moves in either direction before the run is
    // declared hung. The slowest correct gap is the settle pause of wait_idle,
    // which is sized from a full loss pass, so this leaves a wide margin.
    localparam int QUIET_LIMIT = 4000;
    localparam logic [ADDR_W-1:0] MARGIN_ADDR = 3'd0;
    localparam logic signed [63:0] LOSS_CAP = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] GRAD_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] GRAD_LO = -64'sh0000_0000_8000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_t item_word = '0;
    logic strobe;
    out_t result_word;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Input words waiting to be offered, and result words the block owes us.
    in_t pending_words[$];
    out_t due_results[$];

    // Set at a rising edge when the word on the input ports was taken.
    logic took = 1'b0;
    // Percentage of cycles in which the sender holds back a ready word.
    int idle_pct = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    // Our own copy of the block's state, updated as words are accepted.
    logic signed [31:0] class_scores[NUM_CLASSES];
    logic hinge_pos[NUM_CLASSES];
    int n_loaded = 0;
    logic [5:0] held_tgt = '0;
    logic signed [63:0] held_loss = '0;
    int n_viol = 0;
    logic vec_closed = 1'b0;
    logic [30:0] margin_q = MARGIN_RESET;

    multiclass_hinge_loss uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item_word),
        .strobe(strobe),
        .result(result_word),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Works out the result words that one accepted input word causes and
    // appends them to the list of results still due.
    task automatic compute_hinge_results(input in_t w);
        logic signed [63:0] ref_score;
        logic signed [63:0] sj;
        logic signed [63:0] mg;
        logic signed [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] g;
        logic signed [63:0] inc;
        logic signed [63:0] viol_w;
        int viol;
        out_t r;
        if (w.command == CMD_LOAD)
        begin
            // A load after a closed vector starts a fresh one.
            if (vec_closed)
            begin
                n_loaded = 0;
                vec_closed = 1'b0;
            end
            // Scores beyond the capacity are dropped silently.
            if (n_loaded < NUM_CLASSES)
            begin
                class_scores[n_loaded] = w.score;
                n_loaded++;
            end
            if (!w.last)
                return;
            vec_closed = 1'b1;
            held_tgt = w.target_class;
            foreach (hinge_pos[j])
                hinge_pos[j] = 1'b0;
            r = '0;
            r.kind = KIND_LOSS;
            r.final_res = 1'b1;
            if (int'(held_tgt) >= n_loaded)
            begin
                // The correct class was never loaded: error status, no loss.
                held_loss = '0;
                n_viol = 0;
                r.status = STATUS_BAD_CLASS;
            end
            else
            begin
                ref_score = 64'(class_scores[held_tgt]);
                mg = {33'd0, margin_q};
                sum = '0;
                viol = 0;
                for (int j = 0; j < n_loaded; j++)
                begin
                    if (j != int'(held_tgt))
                    begin
                        sj = 64'(class_scores[j]);
                        term = sj - ref_score + mg;
                        if (term > 64'sd0)
                        begin
                            hinge_pos[j] = 1'b1;
                            viol++;
                            sum = sum + term;
                            if (sum > LOSS_CAP)
                                sum = LOSS_CAP;
                        end
                    end
                end
                held_loss = sum;
                n_viol = viol;
                r.loss = sum[30:0];
                r.status = STATUS_OK;
            end
            due_results.push_back(r);
        end
        else
        begin
            // Backward needs a closed vector; otherwise it is ignored.
            if (!vec_closed || n_loaded == 0)
                return;
            g = 64'(w.upstream_grad);
            viol_w = 64'(n_viol);
            for (int j = 0; j < n_loaded; j++)
            begin
                inc = '0;
                if (held_loss != 64'sd0)
                begin
                    if (j == int'(held_tgt))
                    begin
                        inc = -(viol_w * g);
                        if (inc > GRAD_HI)
                            inc = GRAD_HI;
                        else if (inc < GRAD_LO)
                            inc = GRAD_LO;
                    end
                    else if (hinge_pos[j])
                        inc = g;
                end
                r = '0;
                r.kind = KIND_GRAD;
                r.element_index = j[5:0];
                r.gradient = inc[31:0];
                r.status = STATUS_OK;
                r.final_res = (j == n_loaded - 1);
                due_results.push_back(r);
            end
        end
    endtask

    task automatic cmp_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compares one result word with the oldest one still due.
    task automatic check_result(input out_t got);
        out_t want;
        if (due_results.size() == 0)
        begin
            $error("result word with none due: kind %0d loss %0d index %0d gradient %0d",
                   got.kind, got.loss, got.element_index, got.gradient);
            fail_count++;
            return;
        end
        want = due_results.pop_front();
        cmp_field("kind", 64'(want.kind), 64'(got.kind));
        cmp_field("loss", 64'(want.loss), 64'(got.loss));
        cmp_field("element_index", 64'(want.element_index), 64'(got.element_index));
        cmp_field("gradient", 64'(want.gradient), 64'(got.gradient));
        cmp_field("status", 64'(want.status), 64'(got.status));
        cmp_field("final_res", 64'(want.final_res), 64'(got.final_res));
    endtask

    // Monitor and predictor side. Everything here samples at the rising edge,
    // before the block's own updates of that edge take effect. Results are
    // checked before a newly accepted word is predicted, which keeps the
    // order right: a result shown at this edge always belongs to an older word.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            took <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (strobe)
                check_result(result_word);
            // The margin register changes only on a completed write transfer.
            if (psel && penable && pwrite && pready && paddr == MARGIN_ADDR)
                margin_q = pwdata[30:0];
            took <= start && !busy;
            if (start && !busy)
                compute_hinge_results(item_word);
            if ((start && !busy) || strobe || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Driver: at the falling edge, offers the next pending word unless the
    // sender is idling. A word already on the ports is held until taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || took)
        begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                item_word <= pending_words.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    task automatic queue_load(input logic signed [31:0] score, input logic [5:0] tgt,
                              input logic last);
        in_t w;
        w = '0;
        w.command = CMD_LOAD;
        w.score = score;
        w.target_class = tgt;
        // The gradient field is ignored on loads; it still gets random bits.
        w.upstream_grad = $urandom;
        w.last = last;
        pending_words.push_back(w);
    endtask

    task automatic queue_backward(input logic signed [31:0] grad);
        in_t w;
        w = '0;
        w.command = CMD_BACKWARD;
        w.score = $urandom;
        w.target_class = 6'($urandom_range(0, 63));
        w.upstream_grad = grad;
        w.last = 1'($urandom_range(0, 1));
        pending_words.push_back(w);
    endtask

    // Mostly scores within two units of zero so that the hinge terms land on
    // both sides of the margin; now and then any 32-bit value.
    function automatic logic signed [31:0] pick_score();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endfunction

    // Mostly a loaded class; sometimes a class at or beyond the end of the vector.
    function automatic logic [5:0] pick_target(input int n);
        if (n < NUM_CLASSES && $urandom_range(0, 6) == 0)
            return 6'($urandom_range(n, 63));
        return 6'($urandom_range(0, (n > NUM_CLASSES ? NUM_CLASSES : n) - 1));
    endfunction

    // A whole vector of n loads; only the last carries the real target.
    task automatic queue_vector(input int n, input logic [5:0] tgt);
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                queue_load(pick_score(), tgt, 1'b1);
            else
                queue_load(pick_score(), 6'($urandom_range(0, 63)), 1'b0);
        end
    endtask

    // Random traffic for one phase. Most of it is complete vectors followed
    // by a few backward words; the rest is stray backward words and vectors
    // left open across a backward word.
    task automatic fill_phase(input int budget);
        int used;
        int n;
        int k;
        int pick;
        used = 0;
        while (used < budget)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
            begin
                n = ($urandom_range(0, 24) == 0) ? $urandom_range(10, 64) : $urandom_range(1, 6);
                queue_vector(n, pick_target(n));
                k = $urandom_range(0, 2);
                repeat (k) queue_backward($urandom);
                used += n + k;
            end
            else if (pick == 8)
            begin
                queue_backward($urandom);
                used += 1;
            end
            else
            begin
                queue_load(pick_score(), 6'($urandom_range(0, 63)), 1'b0);
                queue_backward($urandom);
                used += 2;
            end
        end
    endtask

    // Waits until every word went in and every result came out, then lets
    // a full loss pass worth of cycles go by so the block is surely idle.
    task automatic wait_idle();
        while (pending_words.size() != 0 || start || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Writes the margin register, then reads it back in a second transfer.
    task automatic write_margin(input logic [30:0] value);
        logic hi_bit;
        hi_bit = 1'($urandom_range(0, 1));
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MARGIN_ADDR;
        pwdata <= {hi_bit, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[30:0] !== value)
        begin
            $error("margin read-back mismatch: expected %0d, got %0d", value, prdata[30:0]);
            fail_count++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        foreach (class_scores[j])
            class_scores[j] = '0;
        foreach (hinge_pos[j])
            hinge_pos[j] = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset margin of 1.0.
        // Backward before any vector was closed gives nothing.
        queue_backward(32'sh0001_0000);
        // Extreme scores against the most negative correct score: the loss
        // saturates, and the violator count times an extreme upstream
        // gradient saturates both ways. A second backward word answers from
        // the same forward pass, and a zero gradient gives zero increments.
        queue_load(32'sh7FFF_FFFF, 6'd63, 1'b0);
        queue_load(32'sh8000_0000, 6'd0, 1'b0);
        queue_load(32'sh0000_0000, 6'd1, 1'b1);
        queue_backward(32'sh8000_0000);
        queue_backward(32'sh7FFF_FFFF);
        queue_backward(32'sh0000_0000);
        // A backward word while a vector is still open is ignored; then the
        // correct class lies beyond the two loaded scores.
        queue_load(32'sh0000_0000, 6'd63, 1'b0);
        queue_backward(32'sh0002_0000);
        queue_load(32'shFFFF_0000, 6'd63, 1'b1);
        // After the error the stored loss is zero: all increments are zero.
        queue_backward(32'sh0001_0000);
        // Correct class far ahead of the other: no violator, zero loss.
        queue_load(32'sh0000_0000, 6'd5, 1'b0);
        queue_load(32'sh0002_0000, 6'd1, 1'b1);
        queue_backward(32'shFFFF_8000);
        // A single class has no other class to compare with.
        queue_load(-32'sd5, 6'd0, 1'b1);
        queue_backward(32'sh0001_0000);
        // A class exactly at the margin is no violator; then a modest gradient.
        queue_load(32'sh0001_0000, 6'd40, 1'b0);
        queue_load(32'sh0000_0000, 6'd0, 1'b1);
        queue_backward(32'sh0000_4000);
        wait_idle();

        // Random phases: margin zero with a steady sender, the widest
        // margin with a bursty sender, a small random margin with a full
        // overflowing vector, and the reset margin again with some idling.
        write_margin(31'd0);
        @(posedge clk);
        idle_pct = 0;
        fill_phase(25);
        wait_idle();

        write_margin(31'h7FFF_FFFF);
        @(posedge clk);
        idle_pct = 51;
        fill_phase(25);
        wait_idle();

        write_margin(31'($urandom_range(0, 32'h0004_0000)));
        @(posedge clk);
        idle_pct = 0;
        // More than the capacity: the extra scores are dropped and the
        // last load still closes the vector, with the top class as target.
        queue_vector(NUM_CLASSES + 2, 6'd63);
        queue_backward($urandom);
        fill_phase(8);
        wait_idle();

        write_margin(31'd65536);
        @(posedge clk);
        idle_pct = 38;
        fill_phase(25);
        wait_idle();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
